@@ sv/assert_macros.svh @@
// assertion macros for the hasher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the cycle after a trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("assertion failed");

// property that holds in the same cycle as a trigger
`define ASSERT_SAME(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("assertion failed");

`endif

@@ sv/sha_pkg.sv @@
// package with sha-256 constants, types and round functions
`timescale 1ns / 1ps
package sha_pkg;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ sv/sha_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ sv/sha_core.sv @@
// sha-256 compression core: one round per cycle, schedule words in a sliding window
`timescale 1ns / 1ps
module sha_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               clear,
    input  logic [7:0]         blk_byte,
    output logic [5:0]         blk_addr,
    output logic               busy,
    input  logic [2:0]         h_idx,
    output sha_pkg::word_t     h_word
);
    // phases: load 64 bytes into the w16 window (pack words), then 64 rounds, folding into h with the last round
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    sha_pkg::word_t pack_reg, pack_next;
    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t h_reg [8];
    sha_pkg::word_t w16_reg [16];

    sha_pkg::word_t w_cur, s0, s1, wnew, t1, t2;
    logic [5:0] ridx;

    assign busy = (state_reg != S_IDLE);
    assign blk_addr = cnt_reg[5:0];
    assign h_word = h_reg[h_idx];
    assign ridx = cnt_reg[5:0];

    // byte delayed by the registered ram read: byte for addr n-1 arrives when cnt==n
    always_comb begin
        s0 = sha_pkg::ror(w16_reg[1], 7) ^ sha_pkg::ror(w16_reg[1], 18) ^ (w16_reg[1] >> 3);
        s1 = sha_pkg::ror(w16_reg[14], 17) ^ sha_pkg::ror(w16_reg[14], 19)
            ^ (w16_reg[14] >> 10);
        wnew = w16_reg[0] + s0 + w16_reg[9] + s1;
        w_cur = (ridx < 6'd16) ? w16_reg[ridx[3:0]] : wnew;
        t1 = v_reg[7] + (sha_pkg::ror(v_reg[4], 6) ^ sha_pkg::ror(v_reg[4], 11)
            ^ sha_pkg::ror(v_reg[4], 25))
            + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
            + sha_pkg::round_k(ridx) + w_cur;
        t2 = (sha_pkg::ror(v_reg[0], 2) ^ sha_pkg::ror(v_reg[0], 13)
            ^ sha_pkg::ror(v_reg[0], 22))
            + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        pack_next = {pack_reg[23:0], blk_byte};
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_LOAD;
                    cnt_next = 7'd0;
                end
            end
            S_LOAD: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd64) begin
                    state_next = S_ROUND;
                    cnt_next = 7'd0;
                end
            end
            S_ROUND: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= 7'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha_pkg::init_h(3'(i));
            end
        end else if (state_reg == S_ROUND && cnt_reg == 7'd63) begin
            h_reg[0] <= h_reg[0] + t1 + t2;
            h_reg[1] <= h_reg[1] + v_reg[0];
            h_reg[2] <= h_reg[2] + v_reg[1];
            h_reg[3] <= h_reg[3] + v_reg[2];
            h_reg[4] <= h_reg[4] + v_reg[3] + t1;
            h_reg[5] <= h_reg[5] + v_reg[4];
            h_reg[6] <= h_reg[6] + v_reg[5];
            h_reg[7] <= h_reg[7] + v_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_LOAD && cnt_reg != 7'd0) begin
            pack_reg <= pack_next;
            if (cnt_reg[1:0] == 2'd0) begin
                for (int i = 0; i < 15; i++) begin
                    w16_reg[i] <= w16_reg[i + 1];
                end
                w16_reg[15] <= pack_next;
            end
        end
        if (state_reg == S_LOAD && cnt_reg == 7'd64) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (state_reg == S_ROUND) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            if (ridx >= 6'd16) begin
                for (int i = 0; i < 15; i++) begin
                    w16_reg[i] <= w16_reg[i + 1];
                end
                w16_reg[15] <= wnew;
            end
        end
    end
endmodule

@@ sv/sha256_byte_stream_hasher.sv @@
// top level: byte buffer ram, padding sequencer, digest output
// an absorb writes one byte into the buffer, and a full block adds the core's load and round phases
// finish: writes the pad byte, zero fill and the bit length, hashing one or two blocks
// no new byte is taken while a block is padded or hashed or the digest is sent
// digest leaves as eight words, one per accepted m_ transfer
// aresetn synchronous active low restores initial hash values and empty counts
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
    output logic        m_tlast    // last_word
);
    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_HASH = 3'd1;
    localparam logic [2:0] T_PAD = 3'd2;
    localparam logic [2:0] T_FINAL = 3'd3;
    localparam logic [2:0] T_OUT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0] pos_reg, pos_next;
    logic last_blk_reg, last_blk_next;
    logic [2:0] oidx_reg, oidx_next;
    logic start, clear, busy, wr_en, started_reg, started_next;
    logic [5:0] wr_addr, core_addr;
    logic [7:0] wr_data, rd_data;
    sha_pkg::word_t h_word;

    sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(core_addr), .rd_data(rd_data)
    );

    sha_core u_core (
        .aclk(aclk), .aresetn(aresetn), .start(start), .clear(clear),
        .blk_byte(rd_data), .blk_addr(core_addr), .busy(busy),
        .h_idx(oidx_reg), .h_word(h_word)
    );

    assign s_tready = (state_reg == T_IDLE);
    assign m_tvalid = (state_reg == T_OUT);
    assign m_tdata = {5'd0, oidx_reg, h_word};
    assign m_tlast = (oidx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        fill_next = fill_reg;
        bits_next = bits_reg;
        pos_next = pos_reg;
        last_blk_next = last_blk_reg;
        oidx_next = oidx_reg;
        started_next = 1'b0;
        start = 1'b0;
        clear = 1'b0;
        wr_en = 1'b0;
        wr_addr = fill_reg;
        wr_data = s_tdata;
        unique case (state_reg)
            T_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == sha_pkg::OP_ABSORB) begin
                        wr_en = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        if (fill_reg == 6'd63) begin
                            start = 1'b1;
                            started_next = 1'b1;
                            last_blk_next = 1'b0;
                            state_next = T_HASH;
                        end
                    end else begin
                        wr_en = 1'b1;
                        wr_data = sha_pkg::PAD_BYTE;
                        pos_next = {1'b0, fill_reg} + 7'd1;
                        state_next = T_PAD;
                    end
                end
            end
            T_PAD: begin
                if (pos_reg == 7'd64) begin
                    start = 1'b1;
                    started_next = 1'b1;
                    last_blk_next = 1'b0;
                    pos_next = 7'd0;
                    state_next = T_HASH;
                end else if (pos_reg == {1'b0, sha_pkg::LEN_POS}) begin
                    state_next = T_FINAL;
                end else begin
                    wr_en = 1'b1;
                    wr_addr = pos_reg[5:0];
                    wr_data = 8'd0;
                    pos_next = pos_reg + 7'd1;
                end
            end
            T_FINAL: begin
                wr_en = 1'b1;
                wr_addr = pos_reg[5:0];
                wr_data = bits_reg[8'(7'd63 - pos_reg) * 8 +: 8];
                pos_next = pos_reg + 7'd1;
                if (pos_reg == 7'd63) begin
                    start = 1'b1;
                    started_next = 1'b1;
                    last_blk_next = 1'b1;
                    state_next = T_HASH;
                end
            end
            T_HASH: begin
                if (!busy && !started_reg) begin
                    if (last_blk_reg) begin
                        oidx_next = 3'd0;
                        state_next = T_OUT;
                    end else if (pos_reg == 7'd0 && fill_reg != 6'd0) begin
                        state_next = T_PAD;
                    end else begin
                        state_next = T_IDLE;
                    end
                end
            end
            T_OUT: begin
                if (m_tready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        clear = 1'b1;
                        fill_next = 6'd0;
                        bits_next = 64'd0;
                        state_next = T_IDLE;
                    end
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            fill_reg <= 6'd0;
            bits_reg <= 64'd0;
            pos_reg <= 7'd0;
            last_blk_reg <= 1'b0;
            oidx_reg <= 3'd0;
            started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            bits_reg <= bits_next;
            pos_reg <= pos_next;
            last_blk_reg <= last_blk_next;
            oidx_reg <= oidx_next;
            started_reg <= started_next;
        end
    end

    `ASSERT_SAME(a_out_idle_core, aclk, aresetn, m_tvalid, !busy)
    `ASSERT_SAME(a_no_in_busy, aclk, aresetn, busy, !s_tready)
    `ASSERT_NEXT(a_last_clears, aclk, aresetn, m_tvalid && m_tready && m_tlast, fill_reg == 6'd0)
endmodule
